// ----- src/page_framebuffer_rect_raster_core_defines.svh -----
// Assertion macros shared by the framebuffer checker.
`ifndef PAGE_FRAMEBUFFER_RECT_RASTER_CORE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_RECT_RASTER_CORE_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define PFRR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds across reset.
`define PFRR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/pfrr_pkg.sv -----
// Shared constants and request codes of the page framebuffer raster core.
`timescale 1ns / 1ps
package pfrr_pkg;
  localparam int DEF_SCREEN_COLUMNS = 128;
  localparam int DEF_SCREEN_PAGES = 8;

  localparam logic [7:0] MASK_ALL = 8'hFF;
  localparam logic [2:0] ROW_LAST = 3'h7;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_FRAME = 2'd3
  } req_t;
endpackage

// ----- src/pfrr_store.sv -----
// Single-port framebuffer memory with registered read data.
`timescale 1ns / 1ps
module pfrr_store #(
  parameter int DEPTH = pfrr_pkg::DEF_SCREEN_COLUMNS * pfrr_pkg::DEF_SCREEN_PAGES,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- src/page_framebuffer_rect_raster_core.sv -----
// Top level of the page framebuffer core with rectangle clipping and raster.
//
//   channel | direction | handshake           | payload
//   request | in        | in_valid / in_stall | req_type, corners, erase, read address
//   result  | out       | out_valid/out_stall | read_data, applied
//
// A read passes through setup and read-wait states; a clear zeroes every byte
// in turn (1024 by default). A fill or outline reads and then writes each byte
// touched through the single memory port, with a start state for each edge.
// After reset a clearing pass over all SCREEN_COLUMNS * SCREEN_PAGES bytes runs
// before the first request is taken. A stalled result holds the core in its
// final state; a new request is taken once that result has been registered.
`timescale 1ns / 1ps
module page_framebuffer_rect_raster_core #(
  parameter int SCREEN_COLUMNS = pfrr_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES = pfrr_pkg::DEF_SCREEN_PAGES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] corner_a_x,
  input  logic signed [15:0] corner_a_y,
  input  logic signed [15:0] corner_b_x,
  input  logic signed [15:0] corner_b_y,
  input  logic               erase,
  input  logic [6:0]         read_column,
  input  logic [2:0]         read_page,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_data,
  output logic               applied
);
  import pfrr_pkg::*;

  localparam int ROWS = 8 * SCREEN_PAGES;
  localparam int DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int PG_W = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam logic signed [17:0] COLS_S = 18'(SCREEN_COLUMNS);
  localparam logic signed [17:0] ROWS_S = 18'(ROWS);

  typedef enum logic [7:0] {
    S_CLR    = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_SETUP  = 8'b00000100,
    S_RDQ    = 8'b00001000,
    S_PSTART = 8'b00010000,
    S_PRD    = 8'b00100000,
    S_PWR    = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t state;
  logic clr_boot;
  logic [ADDR_W-1:0] addr;
  logic [1:0] req_q;
  logic erase_q;
  logic signed [15:0] ax, ay, bx, by;
  logic [6:0] rcol;
  logic [2:0] rpage;
  logic applied_q;
  logic [4:0] edges, cur_edge;
  logic [COL_W-1:0] cx0, cx1, xa, xb, col;
  logic [ROW_W-1:0] cy0, cy1, ya, yb;
  logic [PG_W-1:0] page;

  logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
  logic off, l_in, r_in, t_in, b_in, rd_ok;
  logic [ADDR_W-1:0] pix_addr, mem_addr;
  logic [PG_W-1:0] pg_a, pg_b;
  logic [2:0] lo_bit, hi_bit;
  logic [7:0] mask, rdata, wdata;
  logic we;
  logic [4:0] edges_left;

  function automatic logic [PG_W-1:0] pg_of(input logic [ROW_W-1:0] y);
    return PG_W'(y >> 3);
  endfunction

  always_comb begin
    lo_x = (ax > bx) ? bx : ax;
    hi_x = (ax > bx) ? ax : bx;
    lo_y = (ay > by) ? by : ay;
    hi_y = (ay > by) ? ay : by;
    off = (lo_x >= COLS_S) || (hi_x < 0) || (lo_y >= ROWS_S) || (hi_y < 0);
    l_in = lo_x >= 0;
    r_in = hi_x < COLS_S;
    t_in = lo_y >= 0;
    b_in = hi_y < ROWS_S;
    rd_ok = (32'(rcol) < SCREEN_COLUMNS) && (32'(rpage) < SCREEN_PAGES);
  end

  always_comb begin
    pg_a = pg_of(ya);
    pg_b = pg_of(yb);
    lo_bit = (page == pg_a) ? ya[2:0] : 3'd0;
    hi_bit = (page == pg_b) ? yb[2:0] : ROW_LAST;
    mask = (MASK_ALL << lo_bit) & (MASK_ALL >> (ROW_LAST - hi_bit));
    pix_addr = ADDR_W'(int'(page) * SCREEN_COLUMNS + int'(col));
    mem_addr = (state == S_PRD || state == S_PWR) ? pix_addr : addr;
    we = (state == S_CLR) || (state == S_PWR);
    wdata = (state == S_CLR) ? 8'h00 : (erase_q ? (rdata & ~mask) : (rdata | mask));
    edges_left = edges & ~cur_edge;
  end

  pfrr_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
    .clk   (clk),
    .we    (we),
    .addr  (mem_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_boot <= 1'b1;
      addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          addr <= addr + 1'b1;
          if (addr == ADDR_W'(DEPTH - 1)) begin
            clr_boot <= 1'b0;
            state <= clr_boot ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_q <= req_type;
            erase_q <= erase;
            ax <= corner_a_x;
            ay <= corner_a_y;
            bx <= corner_b_x;
            by <= corner_b_y;
            rcol <= read_column;
            rpage <= read_page;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          applied_q <= 1'b0;
          state <= S_DONE;
          case (req_q)
            REQ_READ: begin
              addr <= ADDR_W'(int'(rpage) * SCREEN_COLUMNS + int'(rcol));
              if (rd_ok) begin
                applied_q <= 1'b1;
                state <= S_RDQ;
              end
            end
            REQ_CLEAR: begin
              addr <= '0;
              applied_q <= 1'b1;
              state <= S_CLR;
            end
            default: begin
              cx0 <= l_in ? COL_W'(lo_x) : '0;
              cx1 <= r_in ? COL_W'(hi_x) : COL_W'(SCREEN_COLUMNS - 1);
              cy0 <= t_in ? ROW_W'(lo_y) : '0;
              cy1 <= b_in ? ROW_W'(hi_y) : ROW_W'(ROWS - 1);
              edges <= (req_q == REQ_FILL) ? 5'b10000 : {1'b0, b_in, t_in, r_in, l_in};
              if (!off && (req_q == REQ_FILL || l_in || r_in || t_in || b_in)) begin
                applied_q <= 1'b1;
                state <= S_PSTART;
              end
            end
          endcase
        end
        S_RDQ: begin
          state <= S_DONE;
        end
        S_PSTART: begin
          if (edges[4]) begin
            cur_edge <= 5'b10000;
            xa <= cx0; xb <= cx1; ya <= cy0; yb <= cy1; col <= cx0;
            page <= pg_of(cy0);
          end else if (edges[0]) begin
            cur_edge <= 5'b00001;
            xa <= cx0; xb <= cx0; ya <= cy0; yb <= cy1; col <= cx0;
            page <= pg_of(cy0);
          end else if (edges[1]) begin
            cur_edge <= 5'b00010;
            xa <= cx1; xb <= cx1; ya <= cy0; yb <= cy1; col <= cx1;
            page <= pg_of(cy0);
          end else if (edges[2]) begin
            cur_edge <= 5'b00100;
            xa <= cx0; xb <= cx1; ya <= cy0; yb <= cy0; col <= cx0;
            page <= pg_of(cy0);
          end else begin
            cur_edge <= 5'b01000;
            xa <= cx0; xb <= cx1; ya <= cy1; yb <= cy1; col <= cx0;
            page <= pg_of(cy1);
          end
          state <= S_PRD;
        end
        S_PRD: begin
          state <= S_PWR;
        end
        S_PWR: begin
          state <= S_PRD;
          if (col == xb) begin
            col <= xa;
            if (page == pg_b) begin
              edges <= edges_left;
              state <= (edges_left == 5'b0) ? S_DONE : S_PSTART;
            end else begin
              page <= page + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            applied <= applied_q;
            read_data <= (req_q == REQ_READ && applied_q) ? rdata : 8'h00;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- src/pfrr_checker.sv -----
// Port-level assertion checker for the page framebuffer core, with its bind.
`timescale 1ns / 1ps
`include "page_framebuffer_rect_raster_core_defines.svh"
module pfrr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         read_data,
  input logic               applied
);
  logic out_wait;
  logic [8:0] out_word;

  assign out_wait = out_valid && out_stall;
  assign out_word = {read_data, applied};

  `PFRR_ASSERT(a_out_hold, clk, rst, out_wait |=> out_valid && $stable(out_word), "Stalled result changed.")
  `PFRR_ASSERT(a_data_applied, clk, rst, out_valid && (|read_data) |-> applied, "Data not applied.")
  `PFRR_ASSERT(a_busy_after_accept, clk, rst, in_valid && !in_stall |=> in_stall, "Took a request while busy.")
  `PFRR_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> in_stall, "Request taken while clearing.")
endmodule

bind page_framebuffer_rect_raster_core pfrr_checker u_pfrr_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the page framebuffer rectangle raster core.
`timescale 1ns / 1ps
module tb;
  import pfrr_pkg::*;

  localparam int COLS = DEF_SCREEN_COLUMNS;
  localparam int PAGES = DEF_SCREEN_PAGES;
  localparam int ROWS = 8 * PAGES;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    req_t kind;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic clr;
    logic [6:0] col;
    logic [2:0] page;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic hit;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic signed [15:0] corner_a_x = '0;
  logic signed [15:0] corner_a_y = '0;
  logic signed [15:0] corner_b_x = '0;
  logic signed [15:0] corner_b_y = '0;
  logic erase = 1'b0;
  logic [6:0] read_column = '0;
  logic [2:0] read_page = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] read_data;
  logic applied;

  request_t pending_requests[$];
  answer_t expected_answers[$];
  logic [7:0] pixels[COLS * PAGES];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit feeding_done = 0;
  bit hold_sender = 0;

  page_framebuffer_rect_raster_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void paint_area(int xa, int xb, int ya, int yb, bit clr);
    int lo, hi;
    logic [7:0] mask;
    for (int p = ya / 8; p <= yb / 8; p++) begin
      lo = (ya > 8 * p) ? ya - 8 * p : 0;
      hi = (yb < 8 * p + 7) ? yb - 8 * p : 7;
      mask = (MASK_ALL << lo) & (MASK_ALL >> (7 - hi));
      for (int x = xa; x <= xb; x++) begin
        if (clr) pixels[p * COLS + x] &= ~mask;
        else pixels[p * COLS + x] |= mask;
      end
    end
  endfunction

  function automatic answer_t raster_request(request_t r);
    answer_t a;
    int x0, x1, y0, y1, t, cx0, cx1, cy0, cy1;
    bit l_in, r_in, t_in, b_in;
    a = '0;
    case (r.kind)
      REQ_READ: begin
        if (r.col < COLS && r.page < PAGES) begin
          a.data = pixels[r.page * COLS + r.col];
          a.hit = 1'b1;
        end
      end
      REQ_CLEAR: begin
        foreach (pixels[i]) pixels[i] = '0;
        a.hit = 1'b1;
      end
      default: begin
        x0 = r.ax; x1 = r.bx; y0 = r.ay; y1 = r.by;
        if (x0 > x1) begin t = x0; x0 = x1; x1 = t; end
        if (y0 > y1) begin t = y0; y0 = y1; y1 = t; end
        if (!(x0 >= COLS || x1 < 0 || y0 >= ROWS || y1 < 0)) begin
          l_in = x0 >= 0; r_in = x1 < COLS; t_in = y0 >= 0; b_in = y1 < ROWS;
          cx0 = l_in ? x0 : 0;
          cx1 = r_in ? x1 : COLS - 1;
          cy0 = t_in ? y0 : 0;
          cy1 = b_in ? y1 : ROWS - 1;
          if (r.kind == REQ_FILL) begin
            paint_area(cx0, cx1, cy0, cy1, r.clr);
            a.hit = 1'b1;
          end else if (l_in || r_in || t_in || b_in) begin
            if (l_in) paint_area(x0, x0, cy0, cy1, r.clr);
            if (r_in) paint_area(x1, x1, cy0, cy1, r.clr);
            if (t_in) paint_area(cx0, cx1, y0, y0, r.clr);
            if (b_in) paint_area(cx0, cx1, y1, y1, r.clr);
            a.hit = 1'b1;
          end
        end
      end
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] pick_coord(int span);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'(int'($urandom_range(0, span + 7)) - 4);
    if (r < 8) return 16'(int'($urandom_range(0, 400)) - 200);
    return 16'($urandom());
  endfunction

  function automatic request_t make_request(req_t kind, int ax, int ay, int bx, int by,
                                            bit clr);
    request_t r;
    r.kind = kind;
    r.ax = 16'(ax); r.ay = 16'(ay); r.bx = 16'(bx); r.by = 16'(by);
    r.clr = clr;
    r.col = 7'($urandom());
    r.page = 3'($urandom());
    return r;
  endfunction

  initial begin
    request_t r;
    int k;
    foreach (pixels[i]) pixels[i] = '0;
    pending_requests.push_back(make_request(REQ_FILL, 0, 0, COLS - 1, ROWS - 1, 0));
    pending_requests.push_back(make_request(REQ_FILL, 10, 10, 3, 2, 1));
    pending_requests.push_back(make_request(REQ_FRAME, -32768, -32768, 32767, 32767, 0));
    pending_requests.push_back(make_request(REQ_FRAME, -5, -5, 140, 70, 1));
    pending_requests.push_back(make_request(REQ_FRAME, 127, 63, 127, 63, 1));
    pending_requests.push_back(make_request(REQ_FILL, 200, 0, 300, 10, 0));
    pending_requests.push_back(make_request(REQ_FILL, 0, -9, 5, -1, 0));
    pending_requests.push_back(make_request(REQ_FRAME, 40, -30, 2, 90, 0));
    pending_requests.push_back(make_request(REQ_FRAME, 5, 5, 20, 5, 0));
    pending_requests.push_back(make_request(REQ_FILL, 32767, 32767, -32768, -32768, 1));
    pending_requests.push_back(make_request(REQ_FRAME, 3, 7, 60, 8, 0));
    for (k = 0; k < 4; k++) begin
      r = make_request(REQ_READ, 0, 0, 0, 0, k[0]);
      r.col = (k < 2) ? 7'd127 : 7'd0;
      r.page = (k[0]) ? 3'd7 : 3'd0;
      pending_requests.push_back(r);
    end
    r = make_request(REQ_READ, -1, -1, -1, -1, 1);
    r.col = 7'h55; r.page = 3'h2;
    pending_requests.push_back(r);
    r.col = 7'h2A; r.page = 3'h5;
    pending_requests.push_back(r);
    pending_requests.push_back(make_request(REQ_CLEAR, -1, -1, -1, -1, 1));
    for (k = 0; k < 550; k++) begin
      case ($urandom_range(0, 19))
        0: r = make_request(REQ_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                            1'($urandom()));
        1, 2, 3, 4, 5, 6: r = make_request(REQ_READ, $urandom(), $urandom(), $urandom(),
                                           $urandom(), 1'($urandom()));
        7, 8, 9, 10, 11: r = make_request(REQ_FILL, pick_coord(COLS), pick_coord(ROWS),
                                          pick_coord(COLS), pick_coord(ROWS),
                                          $urandom_range(0, 3) == 0);
        default: r = make_request(REQ_FRAME, pick_coord(COLS), pick_coord(ROWS),
                                  pick_coord(COLS), pick_coord(ROWS),
                                  $urandom_range(0, 3) == 0);
      endcase
      pending_requests.push_back(r);
    end
    feeding_done = 1;
  end

  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_answers.push_back(raster_request(pending_requests.pop_front()));
        if (pending_requests.size() == 300) hold_sender = 1;
        send_gap = pick_gap();
      end
      if (hold_sender && expected_answers.size() == 0 && !(in_valid)) hold_sender = 0;
      if (send_gap > 0 || hold_sender || pending_requests.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid <= 1'b0;
      end else begin
        r = pending_requests[0];
        in_valid <= 1'b1;
        req_type <= r.kind;
        corner_a_x <= r.ax;
        corner_a_y <= r.ay;
        corner_b_x <= r.bx;
        corner_b_y <= r.by;
        erase <= r.clr;
        read_column <= r.col;
        read_page <= r.page;
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: data %h applied %b",
                                         read_data, applied);
        end else begin
          want = expected_answers.pop_front();
          if (want.data !== read_data || want.hit !== applied) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected data %h applied %b, got data %h applied %b",
                       want.data, want.hit, read_data, applied);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        wait (feeding_done && pending_requests.size() == 0 && !in_valid
              && expected_answers.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Regression FAIL");
      end
    join_any
    $finish;
  end
endmodule
